// ===== sv/udpdt_pkg.sv =====
// ----------------------------------------------------------------------------
// udpdt_pkg
// Types and constants shared by the udp port demux table and its entry store.
// ----------------------------------------------------------------------------
package udpdt_pkg;

    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_ALLOC   = 3'd1;
    localparam logic [2:0] OP_BIND    = 3'd2;
    localparam logic [2:0] OP_SETADDR = 3'd3;
    localparam logic [2:0] OP_LOOKUP  = 3'd4;

    localparam logic [15:0] EPHEMERAL_FLOOR = 16'd1024;
    localparam logic [15:0] UDP_HDR_LEN     = 16'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_READ,
        ST_MODIFY,
        ST_LOOKUP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [31:0] remote_addr;
        logic [15:0] remote_port;
        logic [15:0] local_port;
        logic [15:0] peer_port;
    } t_entry;

endpackage

// ===== sv/udp_port_demux_table.sv =====
// ----------------------------------------------------------------------------
// udp_port_demux_table
// Table of UDP endpoints: clear, allocate, bind ports, set remote address and
// receive lookup, one operation per item and one result item per operation.
// ----------------------------------------------------------------------------
// One item is in work at a time; the input is ready again once the result is
// handed to the output register. Allocate walks the active bits one entry per
// cycle, and lookup streams the entry RAM through its single read port, one
// entry per cycle, comparing each against the datagram. A result waiting at
// the output does not hold off the next item, only its completion.
module udp_port_demux_table import udpdt_pkg::*; #(
    parameter int ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [2:0]  i_entry_index,
    input  logic [31:0] i_addr,
    input  logic [15:0] i_remote_port,
    input  logic [15:0] i_local_port,
    input  logic [15:0] i_udp_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic [2:0]  o_slot,
    output logic [15:0] o_bound_port,
    output logic [15:0] o_learned_peer_port,
    output logic [15:0] o_payload_length
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    t_state             r_state, n_state;
    logic [2:0]         r_op, n_op;
    logic [2:0]         r_entry_idx, n_entry_idx;
    logic [31:0]        r_addr, n_addr;
    logic [15:0]        r_rport, n_rport;
    logic [15:0]        r_lport, n_lport;
    logic [15:0]        r_ulen, n_ulen;
    logic [CW-1:0]      r_scan, n_scan;
    logic               r_pend, n_pend;
    logic [IW-1:0]      r_pend_idx, n_pend_idx;
    logic [ENTRIES-1:0] r_active, n_active;
    logic [15:0]        r_next_eph, n_next_eph;
    logic               r_res_ok, n_res_ok;
    logic [2:0]         r_res_slot, n_res_slot;
    logic [15:0]        r_res_bound, n_res_bound;
    logic [15:0]        r_res_peer, n_res_peer;
    logic [15:0]        r_res_plen, n_res_plen;
    logic               r_out_valid, n_out_valid;
    logic               r_out_ok, n_out_ok;
    logic [2:0]         r_out_slot, n_out_slot;
    logic [15:0]        r_out_bound, n_out_bound;
    logic [15:0]        r_out_peer, n_out_peer;
    logic [15:0]        r_out_plen, n_out_plen;

    logic               in_fire;
    logic               out_free;
    logic               in_range;
    logic               st_clear;
    logic               st_wr_en;
    logic [IW-1:0]      st_wr_addr;
    t_entry             st_wr_data;
    logic               st_rd_en;
    logic [IW-1:0]      st_rd_addr;
    t_entry             st_rd_data;
    logic               lk_hit;
    logic               lk_last;
    logic [15:0]        lk_peer;
    logic [15:0]        plen;
    logic [15:0]        eph;
    logic [IW-1:0]      alloc_idx;
    logic               alloc_last;

    assign in_fire    = i_valid && o_ready;
    assign out_free   = !r_out_valid || i_ready;
    assign in_range   = int'(i_entry_index) < ENTRIES;
    assign alloc_idx  = r_scan[IW-1:0];
    assign alloc_last = r_scan == CW'(ENTRIES - 1);
    assign plen       = (r_ulen > UDP_HDR_LEN) ? r_ulen - UDP_HDR_LEN : '0;
    assign eph        = (r_next_eph < EPHEMERAL_FLOOR) ? EPHEMERAL_FLOOR : r_next_eph;
    assign lk_hit     = r_pend && r_active[r_pend_idx]
                        && (st_rd_data.remote_addr == '0 || st_rd_data.remote_addr == r_addr)
                        && st_rd_data.local_port == r_lport;
    assign lk_last    = r_pend_idx == IW'(ENTRIES - 1);
    assign lk_peer    = (st_rd_data.peer_port == '0) ? r_rport : st_rd_data.peer_port;

    udpdt_store #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (st_clear),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_opcode)
                        OP_CLEAR:            n_state = ST_FINISH;
                        OP_ALLOC:            n_state = ST_ALLOC;
                        OP_BIND, OP_SETADDR: n_state = in_range ? ST_READ : ST_FINISH;
                        OP_LOOKUP:           n_state = ST_LOOKUP;
                        default:             n_state = ST_FINISH;
                    endcase
                end
            end
            ST_ALLOC: begin
                if (!r_active[alloc_idx] || alloc_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_READ:   n_state = ST_MODIFY;
            ST_MODIFY: n_state = ST_FINISH;
            ST_LOOKUP: begin
                if (r_pend && (lk_hit || lk_last)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_op        = r_op;
        n_entry_idx = r_entry_idx;
        n_addr      = r_addr;
        n_rport     = r_rport;
        n_lport     = r_lport;
        n_ulen      = r_ulen;
        n_scan      = r_scan;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_active    = r_active;
        n_next_eph  = r_next_eph;
        n_res_ok    = r_res_ok;
        n_res_slot  = r_res_slot;
        n_res_bound = r_res_bound;
        n_res_peer  = r_res_peer;
        n_res_plen  = r_res_plen;
        n_out_valid = r_out_valid && !i_ready;
        n_out_ok    = r_out_ok;
        n_out_slot  = r_out_slot;
        n_out_bound = r_out_bound;
        n_out_peer  = r_out_peer;
        n_out_plen  = r_out_plen;
        st_clear    = 1'b0;
        st_wr_en    = 1'b0;
        st_wr_addr  = IW'(r_entry_idx);
        st_wr_data  = st_rd_data;
        st_rd_en    = 1'b0;
        st_rd_addr  = IW'(r_entry_idx);
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_op        = i_opcode;
                    n_entry_idx = i_entry_index;
                    n_addr      = i_addr;
                    n_rport     = i_remote_port;
                    n_lport     = i_local_port;
                    n_ulen      = i_udp_length;
                    n_scan      = '0;
                    n_pend      = 1'b0;
                    n_res_ok    = 1'b0;
                    n_res_slot  = '0;
                    n_res_bound = '0;
                    n_res_peer  = '0;
                    n_res_plen  = '0;
                    if (i_opcode == OP_CLEAR) begin
                        st_clear = 1'b1;
                        n_active = '0;
                        n_res_ok = 1'b1;
                    end
                end
            end
            ST_ALLOC: begin
                if (!r_active[alloc_idx]) begin
                    n_active[alloc_idx] = 1'b1;
                    n_res_ok            = 1'b1;
                    n_res_slot          = 3'(alloc_idx);
                end else if (!alloc_last) begin
                    n_scan = CW'(r_scan + 1'b1);
                end
            end
            ST_READ: begin
                st_rd_en = 1'b1;
            end
            ST_MODIFY: begin
                st_wr_en   = 1'b1;
                n_res_ok   = 1'b1;
                n_res_slot = r_entry_idx;
                if (r_op == OP_BIND) begin
                    if (r_rport != '0) begin
                        st_wr_data.remote_port = r_rport;
                    end
                    if (r_lport != '0) begin
                        st_wr_data.local_port = r_lport;
                    end else begin
                        st_wr_data.local_port = eph;
                        n_next_eph            = eph + 16'd1;
                    end
                    n_res_bound = st_wr_data.local_port;
                    n_res_peer  = st_rd_data.peer_port;
                end else begin
                    st_wr_data.remote_addr = r_addr;
                end
            end
            ST_LOOKUP: begin
                st_rd_addr = r_scan[IW-1:0];
                if (int'(r_scan) < ENTRIES) begin
                    st_rd_en   = 1'b1;
                    n_scan     = CW'(r_scan + 1'b1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_scan[IW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (lk_hit) begin
                    st_wr_en             = 1'b1;
                    st_wr_addr           = r_pend_idx;
                    st_wr_data.peer_port = lk_peer;
                    n_res_ok             = 1'b1;
                    n_res_slot           = 3'(r_pend_idx);
                    n_res_bound          = st_rd_data.local_port;
                    n_res_peer           = lk_peer;
                    n_res_plen           = plen;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_slot  = r_res_slot;
                    n_out_bound = r_res_bound;
                    n_out_peer  = r_res_peer;
                    n_out_plen  = r_res_plen;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan      <= '0;
            r_pend      <= 1'b0;
            r_active    <= '0;
            r_next_eph  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_pend      <= n_pend;
            r_active    <= n_active;
            r_next_eph  <= n_next_eph;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_entry_idx <= n_entry_idx;
        r_addr      <= n_addr;
        r_rport     <= n_rport;
        r_lport     <= n_lport;
        r_ulen      <= n_ulen;
        r_pend_idx  <= n_pend_idx;
        r_res_ok    <= n_res_ok;
        r_res_slot  <= n_res_slot;
        r_res_bound <= n_res_bound;
        r_res_peer  <= n_res_peer;
        r_res_plen  <= n_res_plen;
        r_out_ok    <= n_out_ok;
        r_out_slot  <= n_out_slot;
        r_out_bound <= n_out_bound;
        r_out_peer  <= n_out_peer;
        r_out_plen  <= n_out_plen;
    end

    assign o_ready             = r_state == ST_IDLE;
    assign o_valid             = r_out_valid;
    assign o_ok                = r_out_ok;
    assign o_slot              = r_out_slot;
    assign o_bound_port        = r_out_bound;
    assign o_learned_peer_port = r_out_peer;
    assign o_payload_length    = r_out_plen;

    // a failed item carries an all-zero result
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_slot == '0 && o_bound_port == '0
                             && o_learned_peer_port == '0 && o_payload_length == '0)
        else $error("failed result with nonzero fields");

    // only one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_ready)
        else $error("item accepted while another is in work");

    // payload length only reported on a match
    a_plen_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_payload_length != '0 |-> o_ok)
        else $error("payload length without match");

    // scan pointer never goes beyond ENTRIES, one past the last entry
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_scan) <= ENTRIES)
        else $error("scan pointer beyond table");

    // a successful allocate leaves the reported entry active
    a_alloc_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ALLOC && !r_active[alloc_idx] |=> r_active[$past(alloc_idx)])
        else $error("allocated entry not active");

endmodule

// ===== sv/udpdt_store.sv =====
// ----------------------------------------------------------------------------
// udpdt_store
// Entry memory with one write and one registered read port; per-entry valid
// bits make a cleared or never-written entry read as all zero.
// ----------------------------------------------------------------------------
module udpdt_store import udpdt_pkg::*; #(
    parameter int ENTRIES = 8,
    parameter int IW      = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry               r_mem [0:ENTRIES-1];
    logic [ENTRIES-1:0]   r_valid;
    t_entry               r_rd_word;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_word : '0;

endmodule
